>>> rtl/rtmp_pkg.sv
// ----------------------------------------------------------------------------
// Recurrence term package
// Shared constants, command and status types, and the modular helper used by
// the controller and the datapath of the recurrence term block.
// ----------------------------------------------------------------------------
package rtmp_pkg;

   // Default width of the exponent that is scanned.
   localparam int INDEX_BITS_DEF = 63;

   // Modulus and arithmetic widths.
   localparam int VAL_W = 30;
   localparam int SUM_W = 62;
   localparam int PROD_W = 60;
   localparam int RES_W = 32;
   localparam int Q_W = 33;
   localparam int RSP_W = 32;
   localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;

   // Barrett factor floor(2^62 / prime), for sums below 2^62.
   localparam logic [63:0] MU_FULL = (64'd1 << 62) / 64'd1000000007;
   localparam logic [Q_W-1:0] BARRETT_MU = MU_FULL[Q_W-1:0];

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BIT,
      ST_PREP,
      ST_MUL,
      ST_RED1,
      ST_RED2,
      ST_RED3,
      ST_FIX1,
      ST_FIX2,
      ST_COMMIT,
      ST_FIN
   } state_type;

   // Datapath operations.
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_PREP,
      DP_MUL,
      DP_RED1,
      DP_RED2,
      DP_RED3,
      DP_FIX1,
      DP_FIX2,
      DP_COMMIT,
      DP_OUT
   } dp_step_type;

   typedef struct packed {
      dp_step_type step;
      logic        square;
      logic [1:0]  row;
      logic [1:0]  col;
      logic [1:0]  k;
   } dp_cmd_type;

   typedef struct packed {
      logic expo_zero;
      logic expo_lsb;
   } dp_status_type;

   // One conditional subtraction of the prime.
   function automatic logic [RES_W-1:0] mod_fix(input logic [RES_W-1:0] r);
      logic [RES_W-1:0] p;
      p = RES_W'(PRIME);
      return (r >= p) ? (r - p) : r;
   endfunction

endpackage

>>> rtl/recurrence_term_by_matrix_power.sv
// ----------------------------------------------------------------------------
// Recurrence term by matrix power
// Top level: returns term n of a fixed linear recurrence modulo 1000000007.
// ----------------------------------------------------------------------------
// The block takes one index n at a time and raises the step matrix
// [[3,2,1],[1,1,0],[0,0,1]] to the power n-1 by square-and-multiply from the
// least significant exponent bit, then returns the first component for the
// start vector (1,0,1). Every 3x3 modular product runs on one shared
// multiplier, one entry at a time, between a load of the operand matrix and
// a store of the product. The time from transfer to result grows with the
// bit length of n-1 and with its number of set bits. An index of zero wraps
// to an all-ones exponent. The result waits in an output register, and the
// next index is taken while it does.
module recurrence_term_by_matrix_power #(
   parameter int INDEX_BITS = rtmp_pkg::INDEX_BITS_DEF,
   localparam int TDATA_W = ((INDEX_BITS + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [TDATA_W-1:0]         req_tdata,  // term_index
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [rtmp_pkg::RSP_W-1:0] rsp_tdata   // term_value
);
   import rtmp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer.
   rtmp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Matrix arithmetic.
   rtmp_dpath #(
      .INDEX_BITS (INDEX_BITS)
   ) u_dpath (
      .clock      (clock),
      .term_index (req_tdata[INDEX_BITS-1:0]),
      .cmd        (cmd),
      .status     (status),
      .rsp_data   (rsp_tdata)
   );

endmodule

>>> rtl/rtmp_ctrl.sv
// ----------------------------------------------------------------------------
// Recurrence term controller
// Sequences the exponent bits, the 3x3 products entry by entry and the
// reduction steps, and owns the input ready and the result valid.
// ----------------------------------------------------------------------------
module rtmp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  rtmp_pkg::dp_status_type status,
   output rtmp_pkg::dp_cmd_type   cmd
);
   import rtmp_pkg::*;

   state_type  state_ff, state_in;
   logic       sq_ff, sq_in;
   logic [1:0] row_ff, row_in;
   logic [1:0] col_ff, col_in;
   logic [1:0] k_ff, k_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sq_ff        <= 1'b0;
         row_ff       <= 2'd0;
         col_ff       <= 2'd0;
         k_ff         <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sq_ff        <= sq_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      sq_in        = sq_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd.step     = DP_NOP;
      cmd.square   = sq_ff;
      cmd.row      = row_ff;
      cmd.col      = col_ff;
      cmd.k        = k_ff;
      req_tready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.step = DP_LOAD;
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            if (status.expo_zero) begin
               state_in = ST_FIN;
            end else begin
               sq_in    = ~status.expo_lsb;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.step = DP_PREP;
            row_in   = 2'd0;
            col_in   = 2'd0;
            k_in     = 2'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.step = DP_MUL;
            k_in     = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = ST_RED1;
            end
         end
         ST_RED1: begin
            cmd.step = DP_RED1;
            state_in = ST_RED2;
         end
         ST_RED2: begin
            cmd.step = DP_RED2;
            state_in = ST_RED3;
         end
         ST_RED3: begin
            cmd.step = DP_RED3;
            state_in = ST_FIX1;
         end
         ST_FIX1: begin
            cmd.step = DP_FIX1;
            state_in = ST_FIX2;
         end
         ST_FIX2: begin
            // Store the entry and walk to the next one in row order.
            cmd.step = DP_FIX2;
            k_in     = 2'd0;
            state_in = ST_MUL;
            if (col_ff == 2'd2) begin
               col_in = 2'd0;
               if (row_ff == 2'd2) begin
                  row_in   = 2'd0;
                  state_in = ST_COMMIT;
               end else begin
                  row_in = row_ff + 2'd1;
               end
            end else begin
               col_in = col_ff + 2'd1;
            end
         end
         ST_COMMIT: begin
            cmd.step = DP_COMMIT;
            if (sq_ff) begin
               state_in = ST_BIT;
            end else begin
               sq_in    = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.step     = DP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> rtl/rtmp_dpath.sv
// ----------------------------------------------------------------------------
// Recurrence term datapath
// Holds the power and base matrices and the exponent, and computes one
// modular 3x3 product entry at a time with a shared multiplier and a Barrett
// reduction.
// ----------------------------------------------------------------------------
module rtmp_dpath #(
   parameter int INDEX_BITS = rtmp_pkg::INDEX_BITS_DEF
) (
   input  logic                         clock,
   input  logic [INDEX_BITS-1:0]        term_index,
   input  rtmp_pkg::dp_cmd_type         cmd,
   output rtmp_pkg::dp_status_type      status,
   output logic [rtmp_pkg::RSP_W-1:0]   rsp_data
);
   import rtmp_pkg::*;

   // Step matrix of the recurrence.
   localparam logic [VAL_W-1:0] STEP_M [3][3] = '{
      '{VAL_W'(3), VAL_W'(2), VAL_W'(1)},
      '{VAL_W'(1), VAL_W'(1), VAL_W'(0)},
      '{VAL_W'(0), VAL_W'(0), VAL_W'(1)}
   };

   logic [VAL_W-1:0]      acc_ff  [3][3];
   logic [VAL_W-1:0]      base_ff [3][3];
   logic [VAL_W-1:0]      rhs_ff  [3][3];
   logic [VAL_W-1:0]      tmp_ff  [3][3];
   logic [INDEX_BITS-1:0] expo_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [Q_W-1:0]        q_ff;
   logic [RES_W-1:0]      qp_ff;
   logic [RES_W-1:0]      res_ff;
   logic [RSP_W-1:0]      rsp_ff;

   logic [1:0]            kk;
   logic [2*Q_W-1:0]      q_wide;
   logic [Q_W+VAL_W-1:0]  qp_wide;
   logic [VAL_W:0]        out_sum;
   logic [RES_W-1:0]      out_fix;

   // Operand index, kept in range on the final accumulate cycle.
   assign kk = (cmd.k == 2'd3) ? 2'd0 : cmd.k;

   // Barrett quotient estimate and its multiple of the prime.
   assign q_wide  = (2*Q_W)'(sum_ff[SUM_W-1:VAL_W]) * (2*Q_W)'(BARRETT_MU);
   assign qp_wide = (Q_W+VAL_W)'(q_ff) * (Q_W+VAL_W)'(PRIME);

   // First component of the power applied to the start vector.
   assign out_sum = (VAL_W+1)'(acc_ff[0][0]) + (VAL_W+1)'(acc_ff[0][2]);
   assign out_fix = mod_fix(RES_W'(out_sum));

   // Matrices, exponent and arithmetic pipeline.
   always_ff @(posedge clock) begin
      case (cmd.step)
         DP_LOAD: begin
            expo_ff <= term_index - INDEX_BITS'(1);
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  acc_ff[r][c] <= (r == c) ? VAL_W'(1) : VAL_W'(0);
               end
            end
            base_ff <= STEP_M;
         end
         DP_PREP: begin
            rhs_ff <= cmd.square ? base_ff : acc_ff;
         end
         DP_MUL: begin
            prod_ff <= PROD_W'(base_ff[cmd.row][kk]) * PROD_W'(rhs_ff[kk][cmd.col]);
            if (cmd.k == 2'd0) begin
               sum_ff <= '0;
            end else begin
               sum_ff <= sum_ff + SUM_W'(prod_ff);
            end
         end
         DP_RED1: begin
            q_ff <= q_wide[2*Q_W-2 -: Q_W];
         end
         DP_RED2: begin
            qp_ff <= qp_wide[RES_W-1:0];
         end
         DP_RED3: begin
            res_ff <= sum_ff[RES_W-1:0] - qp_ff;
         end
         DP_FIX1: begin
            res_ff <= mod_fix(res_ff);
         end
         DP_FIX2: begin
            tmp_ff[cmd.row][cmd.col] <= VAL_W'(mod_fix(res_ff));
         end
         DP_COMMIT: begin
            if (cmd.square) begin
               base_ff <= tmp_ff;
               expo_ff <= expo_ff >> 1;
            end else begin
               acc_ff <= tmp_ff;
            end
         end
         DP_OUT: begin
            rsp_ff <= RSP_W'(out_fix[VAL_W-1:0]);
         end
         default: begin
         end
      endcase
   end

   assign status.expo_zero = (expo_ff == '0);
   assign status.expo_lsb  = expo_ff[0];
   assign rsp_data         = rsp_ff;

endmodule

>>> rtl/rtmp_checker.sv
// ----------------------------------------------------------------------------
// Recurrence term checker
// Port-level assertions for the recurrence term block, bound to the top level.
// ----------------------------------------------------------------------------
module rtmp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A stalled result stays offered.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its value.
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Every result is fully reduced and its padding is zero.
   a_rsp_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata < 32'd1000000007)
      else $error("result not reduced modulo the prime");

   // The block is busy in the cycle after an index transfer.
   a_busy : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second index taken while one is in work");

endmodule

bind recurrence_term_by_matrix_power rtmp_checker u_rtmp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recurrence term testbench
// Sends term indices to the matrix power block and checks each term value
// against a square-and-multiply model of its own, under random idling on both
// sides and one long stall of the result side.
// ----------------------------------------------------------------------------

// Expected term values, worked out when an index transfer is accepted.
class term_scoreboard;
   typedef longint unsigned mat3_type[3][3];
   localparam longint unsigned MODULUS = 64'd1000000007;

   logic [31:0] pending_terms[$];
   int          mismatches;

   function new();
      mismatches = 0;
   endfunction

   // Product x*y with every entry reduced below the modulus.
   function void mat_mul(input mat3_type x, input mat3_type y, output mat3_type r);
      longint unsigned sum;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sum = 0;
            for (int k = 0; k < 3; k++) begin
               sum = (sum + x[i][k] * y[k][j]) % MODULUS;
            end
            r[i][j] = sum;
         end
      end
   endfunction

   // Term n: step matrix raised to n-1, exponent taken in 63 bits.
   function logic [31:0] term_of(input logic [63:0] index);
      mat3_type        base;
      mat3_type        power;
      mat3_type        tmp;
      logic [62:0]     expo;
      longint unsigned val;
      base = '{'{3, 2, 1}, '{1, 1, 0}, '{0, 0, 1}};
      power = '{'{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}};
      expo = index[62:0] - 63'd1;
      for (int b = 0; b < 63; b++) begin
         if (expo[b]) begin
            mat_mul(base, power, tmp);
            power = tmp;
         end
         mat_mul(base, base, tmp);
         base = tmp;
      end
      val = (power[0][0] + power[0][2]) % MODULUS;
      return {2'b00, val[29:0]};
   endfunction

   function void note_index(input logic [63:0] index);
      pending_terms.push_back(term_of(index));
   endfunction

   function void check_term(input logic [31:0] got);
      logic [31:0] want;
      if (pending_terms.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected term value %0d", got);
         return;
      end
      want = pending_terms.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: term value expected %0d, got %0d", want, got);
      end
   endfunction
endclass

module tb;
   import rtmp_pkg::*;

   localparam int CYCLE_LIMIT = 30000000;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int LONG_HOLD_CYCLES = 4000;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [63:0]      req_tdata;  // term_index, bit 63 padding
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;  // term_value

   term_scoreboard   terms;
   int               send_idle_pct;
   int               recv_stall_pct;
   logic             long_hold;
   int               cycle_count;

   recurrence_term_by_matrix_power u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offer one index, with a random gap first, and wait for its transfer.
   task automatic send_index(input logic [63:0] index);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= index;
      do @(posedge clock);
      while (!req_tready);
      terms.note_index(index);
   endtask

   // Mostly short indices; a few span the full 63 bits.
   function automatic logic [63:0] random_index();
      logic [63:0] v;
      int          len;
      v = {$urandom, $urandom};
      if ($urandom_range(0, 99) >= 3) begin
         len = $urandom_range(1, 10);
         v[62:0] = v[62:0] & ((63'd1 << len) - 63'd1);
         if (v[62:0] == 63'd0)
            v[0] = 1'b1;
      end
      return v;
   endfunction

   // Long result stall early in the run, while indices keep being offered.
   initial begin
      long_hold = 1'b0;
      wait (reset === 1'b0);
      repeat (20) @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   // Result side: check each transfer, then choose the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         terms.check_term(rsp_tdata);
      if (long_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Stimulus.
   initial begin
      logic [63:0] directed[$];
      terms = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Smallest indices, index zero wrapping to an all-ones exponent, the
      // largest index, alternating patterns and a set padding bit.
      directed = '{64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd0,
                   64'h7FFF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000,
                   64'h4000_0000_0000_0001, 64'h0000_0001_0000_0000,
                   64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA,
                   64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'd1000000007, 64'd1000000008, 64'd64};
      foreach (directed[i])
         send_index(directed[i]);

      // Random phases: none, sender idling, result stalling, both.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 61 : (phase == 3) ? 28 : 0;
         recv_stall_pct = (phase == 2) ? 61 : (phase == 3) ? 28 : 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_index(random_index());
      end
      req_tvalid <= 1'b0;

      while (terms.pending_terms.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      if (terms.mismatches == 0 && terms.pending_terms.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

>>> files.f
rtl/rtmp_pkg.sv
rtl/rtmp_ctrl.sv
rtl/rtmp_dpath.sv
rtl/recurrence_term_by_matrix_power.sv
rtl/rtmp_checker.sv
tb/tb.sv
